FILE: rtl/csls_pkg.sv
// Shared types, constants and scan functions for the comment-stripping line splitter.
package csls_pkg;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;

  localparam int unsigned MaxRes = 3;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_C_STYLE    = 2'd0,
    REG_BLOCK_BEG  = 2'd1,
    REG_BLOCK_END  = 2'd2,
    REG_LINE_CHAR  = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    M_NORMAL = 3'd0,
    M_HELD   = 3'd1,
    M_LINE   = 3'd2,
    M_CBLOCK = 3'd3,
    M_CUSTOM = 3'd4
  } mode_t;

  typedef struct packed {
    logic       c_style_enable;
    logic [7:0] block_begin_char;
    logic [7:0] block_end_char;
    logic [7:0] line_comment_char;
  } cfg_t;

  typedef struct packed {
    mode_t mode;
    logic  star_seen;
    logic  swallow_newline;
    logic  line_open;
  } st_t;

  localparam st_t ST_RESET = '{mode: M_NORMAL, star_seen: 1'b0,
                               swallow_newline: 1'b0, line_open: 1'b0};

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       line_done;
  } res_t;

  typedef struct packed {
    st_t  st;
    logic emit;
    res_t res;
  } step_t;

  function automatic logic is_crlf(logic [7:0] b);
    return (b == CH_CR) || (b == CH_LF);
  endfunction

  // Close the current line: emit a line-done result and arm the CR/LF swallow.
  function automatic step_t end_line(st_t s);
    step_t r;
    r.st                 = s;
    r.st.line_open       = 1'b0;
    r.st.swallow_newline = 1'b1;
    r.st.mode            = M_NORMAL;
    r.emit               = 1'b1;
    r.res                = '{out_char: 8'h00, char_valid: 1'b0, line_done: 1'b1};
    return r;
  endfunction

  // Byte in normal text once the C-style slash check is done.
  function automatic step_t plain_byte(cfg_t cfg, st_t s, logic [7:0] b);
    step_t r;
    r.st   = s;
    r.emit = 1'b0;
    r.res  = '0;
    if (cfg.line_comment_char != 8'h00 && b == cfg.line_comment_char) begin
      if (is_crlf(b)) begin
        r = end_line(s);
      end else begin
        r.st.mode      = M_LINE;
        r.st.line_open = 1'b1;
      end
    end else if (cfg.block_begin_char != 8'h00 && b == cfg.block_begin_char) begin
      if (cfg.block_begin_char == cfg.block_end_char) begin
        if (is_crlf(b)) begin
          r = end_line(s);
        end else begin
          r.st.line_open = 1'b1;
        end
      end else begin
        r.st.mode      = M_CUSTOM;
        r.st.line_open = 1'b1;
      end
    end else if (is_crlf(b)) begin
      r = end_line(s);
    end else begin
      r.emit         = 1'b1;
      r.res          = '{out_char: b, char_valid: 1'b1, line_done: 1'b0};
      r.st.line_open = 1'b1;
    end
    return r;
  endfunction

  // One byte in any mode but the held-slash mode, which the caller resolves first.
  function automatic step_t dispatch(cfg_t cfg, st_t s, logic [7:0] b);
    step_t r;
    st_t   s2;
    r.st   = s;
    r.emit = 1'b0;
    r.res  = '0;
    s2     = s;
    unique case (s.mode)
      M_LINE: begin
        if (is_crlf(b)) begin
          r = end_line(s);
        end
      end
      M_CBLOCK: begin
        if (s.star_seen && b == CH_SLASH) begin
          r.st.mode      = M_NORMAL;
          r.st.star_seen = 1'b0;
        end else begin
          r.st.star_seen = (b == CH_STAR);
        end
      end
      M_CUSTOM: begin
        if (b == cfg.block_end_char) begin
          s2.mode = M_NORMAL;
          if (is_crlf(b)) begin
            r = end_line(s2);
          end else begin
            r.st = s2;
          end
        end
      end
      default: begin
        s2.mode = M_NORMAL;
        if (cfg.c_style_enable && b == CH_SLASH) begin
          r.st           = s2;
          r.st.mode      = M_HELD;
          r.st.line_open = 1'b1;
        end else begin
          r = plain_byte(cfg, s2, b);
        end
      end
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/csls_scan.sv
// Single-pass scan of one text byte: next state and up to three packed results.
module csls_scan
  import csls_pkg::*;
(
  input  cfg_t       cfg,
  input  st_t        st,
  input  logic [7:0] text_byte,
  input  logic       final_byte,
  output st_t        st_next,
  output res_t       res [MaxRes],
  output logic [1:0] res_cnt
);

  step_t      held_plain;
  step_t      body;
  step_t      fin_plain;
  step_t      fin_close;
  st_t        s;
  logic       skip;
  logic [3:0] emit;
  res_t       cand [4];

  always_comb begin
    held_plain = '0;
    body       = '0;
    fin_plain  = '0;
    fin_close  = '0;
    emit       = '0;
    s          = st;

    // swallow a CR/LF that directly follows a line end
    skip              = st.swallow_newline && is_crlf(text_byte) && (st.mode == M_NORMAL);
    s.swallow_newline = 1'b0;

    if (!skip) begin
      if (s.mode == M_HELD) begin
        s.mode = M_NORMAL;
        if (text_byte == CH_SLASH) begin
          s.mode = M_LINE;
        end else if (text_byte == CH_STAR) begin
          s.mode      = M_CBLOCK;
          s.star_seen = 1'b1;
        end else begin
          held_plain = plain_byte(cfg, s, CH_SLASH);
          body       = dispatch(cfg, held_plain.st, text_byte);
          emit[0]    = held_plain.emit;
          emit[1]    = body.emit;
          s          = body.st;
        end
      end else begin
        body    = dispatch(cfg, s, text_byte);
        emit[1] = body.emit;
        s       = body.st;
      end
    end

    if (final_byte) begin
      if (s.mode == M_HELD) begin
        s.mode    = M_NORMAL;
        fin_plain = plain_byte(cfg, s, CH_SLASH);
        emit[2]   = fin_plain.emit;
        s         = fin_plain.st;
      end
      if (s.line_open) begin
        fin_close = end_line(s);
        emit[3]   = 1'b1;
      end
      s = ST_RESET;
    end
    st_next = s;
  end

  assign cand[0] = held_plain.res;
  assign cand[1] = body.res;
  assign cand[2] = fin_plain.res;
  assign cand[3] = fin_close.res;

  // pack the emitted results in order
  always_comb begin
    res     = '{default: '0};
    res_cnt = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (emit[i] && res_cnt != 2'd3) begin
        res[res_cnt] = cand[i];
        res_cnt      = res_cnt + 2'd1;
      end
    end
  end

endmodule

FILE: rtl/comment_stripping_line_splitter_top.sv
// Top level of the comment-stripping line splitter: ports, config, input and result registers.
//
// Splits a byte stream into lines and drops comments. Each request on the slave side carries
// one text byte (tdata) and a final-byte flag (tlast). Every kept byte leaves as one result
// with char_valid set; each line end leaves as a separate result with line_done set and a
// zero character; m_tlast marks the last result caused by one request, and a request may
// cause none (comment bytes, swallowed CR/LF) or up to three. Flow: a request lands in an
// input register, is scanned with the state update into a three-entry result buffer, and
// results drain one per cycle while m_tready is high. A request with zero or one result
// sustains one request per cycle when the output does not stall; after more results the next
// request is scanned in the cycle its predecessor's last result is taken. The user must write
// configuration through cfg_we/cfg_index/cfg_data only while the block is idle (the block does
// not enforce it); reset clears config, scan state, in_vld and result counters, not the data.
module comment_stripping_line_splitter_top
  import csls_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // configuration write port
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // byte stream in
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  input  logic       s_tlast,   // final_byte
  // result stream out
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_char
  output logic [1:0] m_tuser,   // [0] char_valid, [1] line_done
  output logic       m_tlast    // run_last
);

  cfg_t       cfg;
  st_t        st;
  st_t        st_next;

  // input register
  logic       in_vld;
  logic [7:0] in_byte;
  logic       in_last;

  // result buffer
  res_t       rbuf [MaxRes];
  logic [1:0] rcnt;
  logic [1:0] rptr;

  res_t       scan_res [MaxRes];
  logic [1:0] scan_cnt;

  logic       take;
  logic       last_take;
  logic       buf_free;
  logic       process;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_C_STYLE:   cfg.c_style_enable    <= cfg_data[0];
        REG_BLOCK_BEG: cfg.block_begin_char  <= cfg_data;
        REG_BLOCK_END: cfg.block_end_char    <= cfg_data;
        REG_LINE_CHAR: cfg.line_comment_char <= cfg_data;
        default: ;
      endcase
    end
  end

  csls_scan u_scan (
    .cfg        (cfg),
    .st         (st),
    .text_byte  (in_byte),
    .final_byte (in_last),
    .st_next    (st_next),
    .res        (scan_res),
    .res_cnt    (scan_cnt)
  );

  // output side: one buffered result per cycle while m_tready is high
  assign m_tvalid  = (rptr != rcnt);
  assign m_tlast   = ((rptr + 2'd1) == rcnt);
  assign m_tdata   = rbuf[rptr].out_char;
  assign m_tuser   = {rbuf[rptr].line_done, rbuf[rptr].char_valid};
  assign take      = m_tvalid && m_tready;
  assign last_take = take && m_tlast;

  // scan the held request once the buffer is empty or drains this cycle
  assign buf_free  = !m_tvalid || last_take;
  assign process   = in_vld && buf_free;
  assign s_tready  = !in_vld || process;

  // hold the request until it is scanned
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // scan state and result buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= ST_RESET;
      rcnt <= 2'd0;
      rptr <= 2'd0;
    end else if (process) begin
      st   <= st_next;
      rcnt <= scan_cnt;
      rptr <= 2'd0;
    end else if (take) begin
      rptr <= rptr + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      rbuf <= scan_res;
    end
  end

`ifndef SYNTH
  // the read pointer never passes the number of buffered results
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    rptr <= rcnt)
    else $error("result read pointer beyond buffered count");

  // a pending CR/LF swallow only follows a closed line
  a_swallow_closed: assert property (@(posedge clk) disable iff (rst)
    st.swallow_newline |-> !st.line_open)
    else $error("swallow armed while a line is open");

  // the star flag only lives inside a C block comment
  a_star_mode: assert property (@(posedge clk) disable iff (rst)
    st.star_seen |-> (st.mode == M_CBLOCK))
    else $error("star flag set outside a block comment");

  // a scanned final byte leaves the scan state at its reset value
  a_final_flush: assert property (@(posedge clk) disable iff (rst)
    (process && in_last) |=> (st == ST_RESET))
    else $error("state not flushed after final byte");
`endif

endmodule

FILE: bench/tb_comment_stripping_line_splitter_top.sv
// Self-checking testbench for the comment-stripping line splitter.
`timescale 1ns / 100ps

module tb_comment_stripping_line_splitter_top;
  import csls_pkg::*;

  localparam int CycleLimit = 200000;

  // One expected result: kept character or line end, plus the end-of-request mark.
  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       line_done;
    logic       run_last;
  } line_res_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;

  // Shadow copy of the configuration registers.
  logic       c_style_on = 1'b0;
  logic [7:0] begin_mark = '0;
  logic [7:0] close_mark = '0;
  logic [7:0] line_mark = '0;

  // Shadow copy of the scanner state.
  mode_t      scan = M_NORMAL;
  logic       star_pending = 1'b0;
  logic       swallow_next = 1'b0;
  logic       line_busy = 1'b0;

  line_res_t  step_results[$];
  line_res_t  pending_results[$];
  line_res_t  head;

  int         mismatches = 0;
  int         sent_count = 0;
  int         cycle_count = 0;
  logic       quiet = 1'b0;    // when set, neither side idles or stalls

  comment_stripping_line_splitter_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #6 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Hard stop in case the block hangs or loses results.
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("FAILED: results differ");
    $finish;
  end

  // Result side: stall at random, about 14 percent of the time, unless a quiet phase runs.
  always @(posedge clk) m_tready <= quiet || ($urandom_range(99) >= 14);

  // ---------------------------------------------------------------------------
  // Line-result predictor
  // ---------------------------------------------------------------------------

  function automatic logic is_line_break(logic [7:0] b);
    return b == CH_CR || b == CH_LF;
  endfunction

  // Queue one result for the current request; the block never makes more than MaxRes.
  function automatic void add_result(logic [7:0] ch, logic valid, logic done);
    line_res_t r;
    if (step_results.size() < MaxRes) begin
      r = '{out_char: ch, char_valid: valid, line_done: done, run_last: 1'b0};
      step_results.insert(step_results.size(), r);
    end
  endfunction

  // Close the line and arm the swallow of one directly following CR or LF.
  function automatic void close_line();
    add_result(8'h00, 1'b0, 1'b1);
    line_busy    = 1'b0;
    swallow_next = 1'b1;
    scan         = M_NORMAL;
  endfunction

  // Text byte once the slash lookahead is settled: markers first, line marker wins.
  function automatic void plain_text(logic [7:0] b);
    if (line_mark != 8'h00 && b == line_mark) begin
      if (is_line_break(b)) begin
        close_line();
      end else begin
        scan      = M_LINE;
        line_busy = 1'b1;
      end
    end else if (begin_mark != 8'h00 && b == begin_mark) begin
      if (begin_mark == close_mark) begin
        // same byte opens and closes: drop it, and end the line if it is a break
        if (is_line_break(b)) close_line();
        else line_busy = 1'b1;
      end else begin
        scan      = M_CUSTOM;
        line_busy = 1'b1;
      end
    end else if (is_line_break(b)) begin
      close_line();
    end else begin
      add_result(b, 1'b1, 1'b0);
      line_busy = 1'b1;
    end
  endfunction

  function automatic void scan_byte(logic [7:0] b);
    case (scan)
      M_HELD: begin
        scan = M_NORMAL;
        if (b == CH_SLASH) begin
          scan = M_LINE;
        end else if (b == CH_STAR) begin
          // the opening star already counts toward the close
          scan         = M_CBLOCK;
          star_pending = 1'b1;
        end else begin
          // lone slash: resolve it as text, then handle this byte afresh
          plain_text(CH_SLASH);
          scan_byte(b);
        end
      end
      M_LINE: begin
        if (is_line_break(b)) close_line();
      end
      M_CBLOCK: begin
        if (star_pending && b == CH_SLASH) begin
          scan         = M_NORMAL;
          star_pending = 1'b0;
        end else begin
          star_pending = (b == CH_STAR);
        end
      end
      M_CUSTOM: begin
        if (b == close_mark) begin
          scan = M_NORMAL;
          if (is_line_break(b)) close_line();
        end
      end
      default: begin
        scan = M_NORMAL;
        if (c_style_on && b == CH_SLASH) begin
          scan      = M_HELD;
          line_busy = 1'b1;
        end else begin
          plain_text(b);
        end
      end
    endcase
  endfunction

  // Advance the shadow state by one accepted request and queue what it must produce.
  function automatic void predict_line_results(logic [7:0] b, logic fin);
    logic skip;
    skip = 1'b0;
    step_results.delete();
    if (swallow_next) begin
      swallow_next = 1'b0;
      if (is_line_break(b) && scan == M_NORMAL) skip = 1'b1;
    end
    if (!skip) scan_byte(b);
    if (fin) begin
      // flush: a held slash becomes text, an open line closes, comments are dropped
      if (scan == M_HELD) begin
        scan = M_NORMAL;
        plain_text(CH_SLASH);
      end
      if (line_busy) close_line();
      scan         = M_NORMAL;
      star_pending = 1'b0;
      swallow_next = 1'b0;
      line_busy    = 1'b0;
    end
    if (step_results.size() > 0) step_results[step_results.size() - 1].run_last = 1'b1;
    foreach (step_results[i]) pending_results.insert(pending_results.size(), step_results[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: out_char %0h, tuser %0b", m_tdata, m_tuser);
        mismatches++;
      end else begin
        head = pending_results.pop_front();
        if (m_tdata !== head.out_char) begin
          $error("out_char: expected %0h, got %0h", head.out_char, m_tdata);
          mismatches++;
        end
        if (m_tuser[0] !== head.char_valid) begin
          $error("char_valid: expected %0b, got %0b", head.char_valid, m_tuser[0]);
          mismatches++;
        end
        if (m_tuser[1] !== head.line_done) begin
          $error("line_done: expected %0b, got %0b", head.line_done, m_tuser[1]);
          mismatches++;
        end
        if (m_tlast !== head.run_last) begin
          $error("run_last: expected %0b, got %0b", head.run_last, m_tlast);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one byte request, idling at random first, and hold it until accepted.
  task automatic send_text_byte(input logic [7:0] b, input logic fin);
    if (!quiet) begin
      while ($urandom_range(99) < 14) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_line_results(b, fin);
    sent_count++;
  endtask

  // Random-phase byte: flush the stream now and then, breaking sequences in the middle.
  task automatic send_rand(input logic [7:0] b);
    send_text_byte(b, $urandom_range(99) < 3);
  endtask

  // Drop valid, let every expected result drain, then let any result-free request clear.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all four registers, one per cycle, while the block is idle.
  task automatic set_config(input logic c_style, input logic [7:0] beg,
                            input logic [7:0] fin_mark, input logic [7:0] line_char);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_C_STYLE;
    cfg_data  <= {7'd0, c_style};
    @(posedge clk);
    cfg_index <= REG_BLOCK_BEG;
    cfg_data  <= beg;
    @(posedge clk);
    cfg_index <= REG_BLOCK_END;
    cfg_data  <= fin_mark;
    @(posedge clk);
    cfg_index <= REG_LINE_CHAR;
    cfg_data  <= line_char;
    @(posedge clk);
    cfg_we     <= 1'b0;
    c_style_on  = c_style;
    begin_mark  = beg;
    close_mark  = fin_mark;
    line_mark   = line_char;
  endtask

  // Byte weighted toward everything the scanner reacts to.
  function automatic logic [7:0] noise_byte();
    int r;
    r = $urandom_range(99);
    if (r < 12) return CH_SLASH;
    if (r < 22) return CH_STAR;
    if (r < 28) return CH_CR;
    if (r < 34) return CH_LF;
    if (r < 40) return line_mark;
    if (r < 46) return begin_mark;
    if (r < 52) return close_mark;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_word();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) send_rand(8'($urandom_range(8'h20, 8'h7e)));
  endtask

  // One random token: mostly well-formed comments and lines, some noise.
  task automatic send_token();
    int n;
    case ($urandom_range(9))
      0, 1, 2: send_word();
      3: begin
        send_rand($urandom_range(1) ? CH_CR : CH_LF);
        if ($urandom_range(1)) send_rand($urandom_range(1) ? CH_LF : CH_CR);
      end
      4: begin
        send_rand(CH_SLASH);
        send_rand(CH_SLASH);
        send_word();
        send_rand(CH_LF);
      end
      5: begin
        send_rand(CH_SLASH);
        send_rand(CH_STAR);
        n = $urandom_range(0, 5);
        repeat (n) send_rand(noise_byte());
        send_rand(CH_STAR);
        send_rand(CH_SLASH);
      end
      6: begin
        send_rand(line_mark);
        send_word();
        send_rand(CH_CR);
      end
      7: begin
        send_rand(begin_mark);
        send_word();
        if ($urandom_range(1)) send_rand(CH_LF);
        send_rand(close_mark);
      end
      default: send_rand(noise_byte());
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extreme bytes as plain text, CR/LF pairs, an empty line and a final flush.
  task automatic test_plain_bytes();
    set_config(1'b0, 8'h00, 8'h00, 8'h00);
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'hFF, 1'b0);
    send_text_byte(CH_CR, 1'b0);
    send_text_byte(CH_LF, 1'b0);
    send_text_byte(CH_LF, 1'b0);
    send_text_byte("a", 1'b1);
  endtask

  // Slash lookahead: lone slash, slash-slash, slash-star-slash, held slash at the end.
  task automatic test_c_comments();
    set_config(1'b1, 8'h00, 8'h00, 8'h00);
    send_text_byte(CH_SLASH, 1'b0);
    send_text_byte("b", 1'b0);
    send_text_byte(CH_SLASH, 1'b0);
    send_text_byte(CH_SLASH, 1'b0);
    send_text_byte("x", 1'b0);
    send_text_byte(CH_LF, 1'b0);
    send_text_byte(CH_SLASH, 1'b0);
    send_text_byte(CH_STAR, 1'b0);
    send_text_byte(CH_SLASH, 1'b0);
    send_text_byte(CH_SLASH, 1'b1);
  endtask

  // Custom markers: break as line marker, shared begin/end, break as end marker,
  // line marker over begin marker, and a comment cut off by the final byte.
  task automatic test_custom_markers();
    set_config(1'b0, CH_CR, CH_CR, CH_LF);
    send_text_byte("a", 1'b0);
    send_text_byte(CH_CR, 1'b0);
    send_text_byte("b", 1'b0);
    send_text_byte(CH_LF, 1'b0);
    set_config(1'b1, "|", "|", 8'hFF);
    send_text_byte("|", 1'b0);
    send_text_byte(8'hFF, 1'b0);
    send_text_byte(CH_CR, 1'b0);
    set_config(1'b0, "{", CH_CR, "{");
    send_text_byte("{", 1'b0);
    send_text_byte(CH_LF, 1'b0);
    set_config(1'b1, "<", CH_CR, "#");
    send_text_byte("<", 1'b0);
    send_text_byte(CH_LF, 1'b0);
    send_text_byte(CH_CR, 1'b0);
    send_text_byte("<", 1'b0);
    send_text_byte("z", 1'b1);
  endtask

  // Random token streams under several register settings; one phase runs without gaps.
  task automatic test_random_text();
    int target;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config(1'b1, "{", "}", "#");
        1: set_config(1'b0, 8'h00, 8'h00, 8'h00);
        2: set_config(1'b1, CH_STAR, CH_SLASH, CH_SLASH);
        3: set_config(1'b1, 8'hFF, 8'hFF, 8'h01);
        4: set_config(1'b0, "[", CH_LF, CH_CR);
        default: set_config(1'($urandom_range(1)), 8'($urandom_range(255)),
                            8'($urandom_range(255)), 8'($urandom_range(255)));
      endcase
      quiet  = (phase == 1);
      target = sent_count + 70;
      while (sent_count < target) send_token();
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_plain_bytes();
    test_c_comments();
    test_custom_markers();
    test_random_text();
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
